>>> hdl/polyphonic_sine_tone_mixer_assert.svh
// Assertion macros shared by the mixer's modules.
// IMPLY checks a condition in the same cycle, NEXT checks it in the following cycle.
`ifndef POLYPHONIC_SINE_TONE_MIXER_ASSERT_SVH
`define POLYPHONIC_SINE_TONE_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
`define PSTM_ASSERT_IMPLY(name, clk, rstn, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("pstm assertion failed");
`define PSTM_ASSERT_NEXT(name, clk, rstn, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("pstm assertion failed");
`else
`define PSTM_ASSERT_IMPLY(name, clk, rstn, cond, prop)
`define PSTM_ASSERT_NEXT(name, clk, rstn, cond, prop)
`endif
`endif

>>> hdl/pstm_pkg.sv
package pstm_pkg;

    // defaults for the top-level parameters
    localparam int SAMPLE_RATE_HZ_DEF     = 44100;
    localparam int VOICES_DEF             = 7;
    localparam int SINE_TABLE_ENTRIES_DEF = 1024;

    // fixed field widths
    localparam int MAX_VOICES = 7;
    localparam int MASK_W     = 7;
    localparam int S_TDATA_W  = 8;
    localparam int SAMPLE_W   = 16;
    localparam int REG_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int Q_SHIFT    = 15;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE0_FREQ = 3'd1;

    // register reset values
    localparam logic [REG_W-1:0] AMP_RESET = 15'd5000;
    localparam logic [REG_W-1:0] FREQ_RESET [MAX_VOICES] = '{
        15'd1046, 15'd1174, 15'd1318, 15'd1398, 15'd1568, 15'd1760, 15'd1974
    };

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VOICE,
        ST_DIV,
        ST_LOOKUP,
        ST_MUL,
        ST_ACC,
        ST_PH_ADD,
        ST_PH_RED,
        ST_FINISH
    } pstm_state_t;

    // multiply-accumulate controls
    typedef struct packed {
        logic clear;
        logic mul;
        logic acc;
    } pstm_mac_ctl_t;

endpackage

>>> hdl/pstm_sine_rom.sv
module pstm_sine_rom #(
    parameter int SINE_TABLE_ENTRIES = pstm_pkg::SINE_TABLE_ENTRIES_DEF
) (
    input  logic                                  clk,
    input  logic [$clog2(SINE_TABLE_ENTRIES)-1:0] addr,
    output logic signed [pstm_pkg::SAMPLE_W-1:0]  data
);
    import pstm_pkg::*;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Q1.15 sine of entry k: quadrant folding and a Q2.30 Taylor series to x^11
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k);
        logic [63:0] turn;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] mag;
        logic [1:0]  quad;
        turn = ({32'd0, k} << 32) / 64'(SINE_TABLE_ENTRIES);
        quad = turn[31:30];
        r    = turn & (Q30_ONE - 64'd1);
        if (quad[0])
            r = Q30_ONE - r;
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        t    = Q30_ONE - x2 / 64'd110;
        t    = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t    = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t    = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t    = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s    = (x * t) >> 30;
        mag  = (s * 64'd32768 + (Q30_ONE >> 1)) >> 30;
        if (mag > 64'(SAMPLE_MAX))
            mag = 64'(SAMPLE_MAX);
        return quad[1] ? SAMPLE_W'(~mag[SAMPLE_W-1:0] + 16'd1) : mag[SAMPLE_W-1:0];
    endfunction

    // constant table, folded at elaboration
    logic signed [SAMPLE_W-1:0] rom_tbl [SINE_TABLE_ENTRIES];

    for (genvar g = 0; g < SINE_TABLE_ENTRIES; g++)
    begin : g_tbl
        assign rom_tbl[g] = sine_entry(g);
    end

    // registered read
    always_ff @(posedge clk)
    begin
        data <= rom_tbl[addr];
    end

endmodule

>>> hdl/pstm_idx_div.sv
`include "polyphonic_sine_tone_mixer_assert.svh"

// Table index = floor(phase * entries / rate) by reciprocal multiplication.
// The reciprocal is scaled by 2^32 and rounded up; since rate squared stays
// below 2^32 the product's upper bits are the exact floor for every phase below
// the rate, so no correction step follows. done rises in the cycle after start.
module pstm_idx_div #(
    parameter int SAMPLE_RATE_HZ     = pstm_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int SINE_TABLE_ENTRIES = pstm_pkg::SINE_TABLE_ENTRIES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [$clog2(SAMPLE_RATE_HZ)-1:0]     phase,
    output logic                                  done,
    output logic [$clog2(SINE_TABLE_ENTRIES)-1:0] quot
);
    import pstm_pkg::*;

    localparam int PH_W        = $clog2(SAMPLE_RATE_HZ);
    localparam int QW          = $clog2(SINE_TABLE_ENTRIES);
    localparam int RECIP_SHIFT = 32;
    localparam int PROD_W      = RECIP_SHIFT + QW;
    localparam logic [63:0] RECIP_WIDE =
        ((64'(SINE_TABLE_ENTRIES) << RECIP_SHIFT) + 64'(SAMPLE_RATE_HZ) - 64'd1)
        / 64'(SAMPLE_RATE_HZ);
    localparam logic [31:0] RECIP = RECIP_WIDE[31:0];

    logic              done_reg;
    logic [PROD_W-1:0] prod_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= start;
    end

    // one registered multiply by the scaled reciprocal; the product never
    // reaches 2^PROD_W because the quotient stays below the table size
    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= PROD_W'(phase) * PROD_W'(RECIP);
    end

    assign done = done_reg;
    assign quot = prod_reg[PROD_W-1:RECIP_SHIFT];

    `PSTM_ASSERT_NEXT(a_done_follows_start, clk, rst_n, start, done_reg)
    `PSTM_ASSERT_IMPLY(a_phase_below_rate, clk, rst_n, start, phase < PH_W'(SAMPLE_RATE_HZ))
    `PSTM_ASSERT_IMPLY(a_quot_in_table, clk, rst_n, done_reg, {1'b0, quot} < (QW+1)'(SINE_TABLE_ENTRIES))

endmodule

>>> hdl/pstm_mac.sv
// Shared multiplier: amplitude * sine, truncated toward zero, summed, saturated
module pstm_mac #(
    parameter int VOICES = pstm_pkg::VOICES_DEF
) (
    input  logic                                 clk,
    input  pstm_pkg::pstm_mac_ctl_t              ctl,
    input  logic [pstm_pkg::REG_W-1:0]           amplitude,
    input  logic signed [pstm_pkg::SAMPLE_W-1:0] sine,
    output logic [pstm_pkg::SAMPLE_W-1:0]        sample,
    output logic                                 clip
);
    import pstm_pkg::*;

    localparam int PROD_W = REG_W + SAMPLE_W;
    localparam int SUM_W  = SAMPLE_W + $clog2(VOICES) + 1;
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << Q_SHIFT) - 1);
    localparam logic signed [SUM_W-1:0]  POS_LIM    = SUM_W'(SAMPLE_MAX);
    localparam logic signed [SUM_W-1:0]  NEG_LIM    = SUM_W'(SAMPLE_MIN);

    logic signed [SAMPLE_W-1:0] amp_s;
    logic signed [PROD_W:0]     mul_full;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   biased;
    logic signed [SAMPLE_W-1:0] term;
    logic signed [SUM_W-1:0]    sum_reg;

    assign amp_s    = $signed({1'b0, amplitude});
    assign mul_full = amp_s * sine;

    // negative products get a bias so the shift rounds toward zero
    assign biased = prod_reg + (prod_reg[PROD_W-1] ? TRUNC_BIAS : PROD_W'(0));
    assign term   = biased[PROD_W-1:Q_SHIFT];

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
            prod_reg <= mul_full[PROD_W-1:0];
        if (ctl.clear)
            sum_reg <= '0;
        else if (ctl.acc)
            sum_reg <= sum_reg + SUM_W'(term);
    end

    // saturation to 16 bits
    always_comb
    begin
        clip   = 1'b0;
        sample = sum_reg[SAMPLE_W-1:0];
        if (sum_reg > POS_LIM)
        begin
            clip   = 1'b1;
            sample = POS_LIM[SAMPLE_W-1:0];
        end
        else if (sum_reg < NEG_LIM)
        begin
            clip   = 1'b1;
            sample = NEG_LIM[SAMPLE_W-1:0];
        end
    end

endmodule

>>> hdl/polyphonic_sine_tone_mixer.sv
// Channel  Side    Payload
// s_*      in      tdata[6:0] voice_on_mask, one transfer per sample tick
// m_*      out     tdata[15:0] sample_out, tuser[0] clipped, one transfer per tick
// cfg_*    in      cfg_index 0 amplitude, 1..7 voice frequencies; cfg_data[14:0]
//
// A tick runs from IDLE through each voice in turn to FINISH. A sounding voice passes
// VOICE, DIV, LOOKUP, MUL, ACC, PH_ADD and PH_RED, a silent one VOICE, PH_ADD and
// PH_RED; PH_RED stays for each rate subtraction in the phase wrap (0 or 1 at
// 44.1 kHz, at most ceil(32767/rate)).
// s_tready is high only between ticks; a stalled sample holds the sequencer in FINISH.
// Reset restores the register defaults and clears all phases; cfg is always ready.
`include "polyphonic_sine_tone_mixer_assert.svh"

module polyphonic_sine_tone_mixer #(
    parameter int SAMPLE_RATE_HZ     = pstm_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int VOICES             = pstm_pkg::VOICES_DEF,
    parameter int SINE_TABLE_ENTRIES = pstm_pkg::SINE_TABLE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pstm_pkg::S_TDATA_W-1:0]     s_tdata,   // [6:0] voice_on_mask, [7] zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pstm_pkg::SAMPLE_W-1:0]      m_tdata,   // [15:0] sample_out
    output logic                               m_tuser,   // [0] clipped
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pstm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pstm_pkg::REG_W-1:0]         cfg_data
);
    import pstm_pkg::*;

    localparam int PH_W    = $clog2(SAMPLE_RATE_HZ);
    localparam int QW      = $clog2(SINE_TABLE_ENTRIES);
    localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int PA_W    = ((PH_W > REG_W) ? PH_W : REG_W) + 1;

    pstm_state_t state_reg;
    pstm_state_t state_next;

    logic [REG_W-1:0]    amp_reg;
    logic [REG_W-1:0]    freq_reg [VOICES];
    logic [PH_W-1:0]     ph_reg [VOICES];
    logic [MASK_W-1:0]   mask_reg;
    logic [VOICE_W-1:0]  voice_reg;
    logic [PA_W-1:0]     ph_acc_reg;
    logic                m_tvalid_reg;
    logic [SAMPLE_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    logic                 accept;
    logic                 last_voice;
    logic                 ph_wrap;
    logic                 out_free;
    logic                 out_load;
    logic                 div_start;
    logic                 div_done;
    logic [QW-1:0]        div_quot;
    logic signed [SAMPLE_W-1:0] rom_data;
    pstm_mac_ctl_t        mac_ctl;
    logic [SAMPLE_W-1:0]  mix_sample;
    logic                 mix_clip;

    assign accept     = s_tvalid && s_tready;
    assign last_voice = voice_reg == VOICE_W'(VOICES - 1);
    assign ph_wrap    = ph_acc_reg >= PA_W'(SAMPLE_RATE_HZ);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign cfg_ready  = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg <= AMP_RESET;
            for (int k = 0; k < VOICES; k++)
                freq_reg[k] <= FREQ_RESET[k];
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_AMPLITUDE)
                amp_reg <= cfg_data;
            for (int k = 0; k < VOICES; k++)
                if (cfg_index == CFG_IDX_W'(k) + REG_VOICE0_FREQ)
                    freq_reg[k] <= cfg_data;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_VOICE;
            ST_VOICE:  state_next = mask_reg[voice_reg] ? ST_DIV : ST_PH_ADD;
            ST_DIV:    if (div_done) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:    state_next = ST_PH_ADD;
            ST_PH_ADD: state_next = ST_PH_RED;
            ST_PH_RED:
            begin
                if (!ph_wrap)
                    state_next = last_voice ? ST_FINISH : ST_VOICE;
            end
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready      = state_reg == ST_IDLE;
        div_start     = (state_reg == ST_VOICE) && mask_reg[voice_reg];
        mac_ctl.clear = (state_reg == ST_IDLE) && s_tvalid;
        mac_ctl.mul   = state_reg == ST_MUL;
        mac_ctl.acc   = state_reg == ST_ACC;
        out_load      = (state_reg == ST_FINISH) && out_free;
    end

    // sequencer and phase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            voice_reg <= '0;
            for (int k = 0; k < VOICES; k++)
                ph_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                voice_reg <= '0;
            else if ((state_reg == ST_PH_RED) && !ph_wrap)
            begin
                ph_reg[voice_reg] <= PH_W'(ph_acc_reg);
                if (!last_voice)
                    voice_reg <= voice_reg + VOICE_W'(1);
            end
        end
    end

    // tick payload and phase sum
    always_ff @(posedge clk)
    begin
        if (accept)
            mask_reg <= s_tdata[MASK_W-1:0];
        if (state_reg == ST_PH_ADD)
            ph_acc_reg <= PA_W'(ph_reg[voice_reg]) + PA_W'(freq_reg[voice_reg]);
        else if ((state_reg == ST_PH_RED) && ph_wrap)
            ph_acc_reg <= ph_acc_reg - PA_W'(SAMPLE_RATE_HZ);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= mix_sample;
            m_tuser_reg <= mix_clip;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    pstm_idx_div #(
        .SAMPLE_RATE_HZ     (SAMPLE_RATE_HZ),
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .phase (ph_reg[voice_reg]),
        .done  (div_done),
        .quot  (div_quot)
    );

    pstm_sine_rom #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_rom (
        .clk  (clk),
        .addr (div_quot),
        .data (rom_data)
    );

    pstm_mac #(
        .VOICES (VOICES)
    ) u_mac (
        .clk       (clk),
        .ctl       (mac_ctl),
        .amplitude (amp_reg),
        .sine      (rom_data),
        .sample    (mix_sample),
        .clip      (mix_clip)
    );

    `PSTM_ASSERT_IMPLY(a_div_only_in_div, clk, rst_n, div_done, state_reg == ST_DIV)
    `PSTM_ASSERT_IMPLY(a_phase_below_rate, clk, rst_n, state_reg == ST_VOICE, ph_reg[voice_reg] < PH_W'(SAMPLE_RATE_HZ))
    `PSTM_ASSERT_IMPLY(a_clip_saturates, clk, rst_n, m_tvalid_reg && m_tuser_reg, m_tdata_reg == 16'h7FFF || m_tdata_reg == 16'h8000)

endmodule
